>>> rtl/core/dfc_pkg.sv
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared constants, types and byte functions of the datagram framer.
// ----------------------------------------------------------------------------
package dfc_pkg;

   localparam int PAYLOAD_DEPTH  = 512;
   localparam int HEADER_BYTES   = 17;
   localparam int ADDR_BITS      = $clog2(PAYLOAD_DEPTH);
   localparam int COUNT_BITS     = $clog2(PAYLOAD_DEPTH + 1);
   localparam int POS_BITS       = $clog2(PAYLOAD_DEPTH + HEADER_BYTES);
   localparam int HDR_POS_BITS   = $clog2(HEADER_BYTES);
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [7:0] MAGIC_0     = 8'h43;
   localparam logic [7:0] MAGIC_1     = 8'h56;
   localparam logic [7:0] VERSION     = 8'h01;
   localparam logic [7:0] STREAM_ID   = 8'h04;
   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [15:0] MAX_FRAME_RESET = 16'd530;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SINK_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FRAME   = 1'd1;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_PULL = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_PAY,
      ST_PULL
   } state_type;

   typedef struct packed {
      logic push;
      logic start_walk;
      logic hdr_step;
      logic pay_step;
      logic commit;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic keep;
      logic hdr_last;
      logic pay_done;
      logic out_free;
   } status_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic [7:0] header_byte(input logic [HDR_POS_BITS-1:0] pos,
                                              input logic [15:0] len,
                                              input logic [31:0] stamp,
                                              input logic [7:0] check);
      logic [7:0] b;
      unique case (pos)
         5'd0:    b = MAGIC_0;
         5'd1:    b = MAGIC_1;
         5'd2:    b = VERSION;
         5'd4:    b = STREAM_ID;
         5'd6:    b = len[7:0];
         5'd7:    b = len[15:8];
         5'd12:   b = stamp[7:0];
         5'd13:   b = stamp[15:8];
         5'd14:   b = stamp[23:16];
         5'd15:   b = stamp[31:24];
         5'd16:   b = check;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/core/dfc_channels_if.sv
// ----------------------------------------------------------------------------
// dfc channel interfaces
// Valid/ready request and response channels of the datagram framer.
// ----------------------------------------------------------------------------
interface dfc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [7:0]  data_byte;
   logic        end_of_payload;
   logic [31:0] time_us;

   modport source (output valid, output opcode, output data_byte,
                   output end_of_payload, output time_us, input ready);
   modport sink   (input valid, input opcode, input data_byte,
                   input end_of_payload, input time_us, output ready);
endinterface

interface dfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_valid;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_valid,
                   output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_valid,
                   input frame_end, output ready);
endinterface

>>> rtl/core/dfc_ctrl.sv
// ----------------------------------------------------------------------------
// dfc_ctrl
// Sequencer: accepts transactions, walks the CRC, schedules frame reads.
// ----------------------------------------------------------------------------
module dfc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_opcode,
   output logic                req_ready,
   input  dfc_pkg::status_type status,
   output dfc_pkg::cmd_type    cmd
);
   import dfc_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // a pull needs the output register free by the time it loads
            req_ready = (req_opcode == OP_PULL) ? status.out_free : 1'b1;
            accept    = req_valid && req_ready;
            if (accept && req_opcode == OP_PUSH) begin
               cmd.push = 1'b1;
               if (status.keep) begin
                  cmd.start_walk = 1'b1;
                  state_in       = ST_HDR;
               end
            end else if (accept) begin
               state_in = ST_PULL;
            end
         end
         ST_HDR: begin
            cmd.hdr_step = 1'b1;
            if (status.hdr_last) begin
               state_in = ST_PAY;
            end
         end
         ST_PAY: begin
            cmd.pay_step = 1'b1;
            if (status.pay_done) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_PULL: begin
            cmd.load_out = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/dfc_datapath.sv
// ----------------------------------------------------------------------------
// dfc_datapath
// Payload buffer, frame state, CRC accumulator, settings and output register.
// ----------------------------------------------------------------------------
module dfc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dfc_pkg::cmd_type                      cmd,
   output dfc_pkg::status_type                   status,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_end_of_payload,
   input  logic [31:0]                           req_time_us,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [7:0]                            rsp_frame_byte,
   output logic                                  rsp_frame_valid,
   output logic                                  rsp_frame_end,
   input  logic                                  csr_write_enable,
   input  logic [dfc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [dfc_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);
   import dfc_pkg::*;

   localparam logic [POS_BITS:0]   FRAME_HDR = (POS_BITS + 1)'(HEADER_BYTES);
   localparam logic [POS_BITS-1:0] POS_HDR   = POS_BITS'(HEADER_BYTES);
   localparam logic [COUNT_BITS-1:0] DEPTH   = COUNT_BITS'(PAYLOAD_DEPTH);
   localparam logic [COUNT_BITS-1:0] HDR_END = COUNT_BITS'(HEADER_BYTES - 2);

   logic [7:0] mem [PAYLOAD_DEPTH];
   logic [7:0] rd_data_ff;
   logic [ADDR_BITS-1:0] rd_addr;
   logic mem_we;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  ready_ff, ready_in;
   logic [31:0]           stamp_ff, stamp_in;
   logic [7:0]            crc_ff, crc_in;
   logic [POS_BITS-1:0]   rdpos_ff, rdpos_in;
   logic [COUNT_BITS-1:0] walk_ff, walk_in;
   logic                  pend_ff, pend_in;
   logic                  sink_ff, sink_in;
   logic [15:0]           max_ff, max_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  out_fvalid_ff, out_fvalid_in;
   logic                  out_end_ff, out_end_in;

   logic                  has_room;
   logic [COUNT_BITS-1:0] next_count;
   logic [16:0]           frame_len;
   logic [15:0]           len_field;
   logic                  last_byte;

   assign has_room   = count_ff < DEPTH;
   assign next_count = has_room ? count_ff + 1'b1 : count_ff;
   assign frame_len  = 17'(next_count) + 17'(HEADER_BYTES);
   assign len_field  = 16'(count_ff);
   assign last_byte  = ({1'b0, rdpos_ff} + 1'b1) >= (FRAME_HDR + (POS_BITS + 1)'(count_ff));

   assign status.keep     = req_end_of_payload && !ready_ff && sink_ff && !ovf_ff &&
                            has_room && (frame_len < {1'b0, max_ff});
   assign status.hdr_last = walk_ff == HDR_END;
   assign status.pay_done = (walk_ff == count_ff) && !pend_ff;
   assign status.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_frame_byte  = out_byte_ff;
   assign rsp_frame_valid = out_fvalid_ff;
   assign rsp_frame_end   = out_end_ff;

   always_comb begin
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      ready_in      = ready_ff;
      stamp_in      = stamp_ff;
      crc_in        = crc_ff;
      rdpos_in      = rdpos_ff;
      walk_in       = walk_ff;
      pend_in       = pend_ff;
      sink_in       = sink_ff;
      max_in        = max_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_fvalid_in = out_fvalid_ff;
      out_end_in    = out_end_ff;
      mem_we        = 1'b0;
      rd_addr       = ADDR_BITS'(rdpos_ff - POS_HDR);

      if (csr_write_enable) begin
         priority if (csr_index == CSR_SINK_ENABLE) begin
            sink_in = csr_write_data[0];
         end else if (csr_index == CSR_MAX_FRAME) begin
            max_in = csr_write_data[15:0];
         end
      end

      // pushes are dropped while a frame waits to be read
      if (cmd.push && !ready_ff) begin
         mem_we = has_room;
         if (req_end_of_payload && !status.keep) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (has_room) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
         if (status.keep) begin
            stamp_in = req_time_us;
         end
      end

      if (cmd.start_walk) begin
         crc_in  = 8'h00;
         walk_in = '0;
         pend_in = 1'b0;
      end

      if (cmd.hdr_step) begin
         crc_in  = crc8_byte(crc_ff, header_byte(walk_ff[HDR_POS_BITS-1:0], len_field,
                                                 stamp_ff, crc_ff));
         walk_in = status.hdr_last ? '0 : walk_ff + 1'b1;
      end

      // issue one buffer read and fold the previous read each cycle
      if (cmd.pay_step) begin
         if (walk_ff < count_ff) begin
            rd_addr = walk_ff[ADDR_BITS-1:0];
            pend_in = 1'b1;
            walk_in = walk_ff + 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            crc_in = crc8_byte(crc_ff, rd_data_ff);
         end
      end

      if (cmd.commit) begin
         ready_in = 1'b1;
         rdpos_in = '0;
      end

      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         if (!ready_ff) begin
            out_byte_in   = 8'h00;
            out_fvalid_in = 1'b0;
            out_end_in    = 1'b0;
         end else begin
            out_byte_in   = (rdpos_ff < POS_HDR) ?
                            header_byte(rdpos_ff[HDR_POS_BITS-1:0], len_field, stamp_ff, crc_ff) :
                            rd_data_ff;
            out_fvalid_in = 1'b1;
            out_end_in    = last_byte;
            if (last_byte) begin
               ready_in = 1'b0;
               rdpos_in = '0;
               count_in = '0;
               ovf_in   = 1'b0;
            end else begin
               rdpos_in = rdpos_ff + 1'b1;
            end
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[ADDR_BITS-1:0]] <= req_data_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ready_ff     <= 1'b0;
         stamp_ff     <= '0;
         crc_ff       <= '0;
         rdpos_ff     <= '0;
         walk_ff      <= '0;
         pend_ff      <= 1'b0;
         sink_ff      <= 1'b1;
         max_ff       <= MAX_FRAME_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ready_ff     <= ready_in;
         stamp_ff     <= stamp_in;
         crc_ff       <= crc_in;
         rdpos_ff     <= rdpos_in;
         walk_ff      <= walk_in;
         pend_ff      <= pend_in;
         sink_ff      <= sink_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_fvalid_ff <= out_fvalid_in;
      out_end_ff    <= out_end_in;
   end

endmodule

>>> rtl/core/datagram_framer_crc8.sv
// Push transaction: the last push of a kept frame adds a CRC walk over the
// header bytes before the check byte, then the payload (one header or buffer
// byte per cycle, bound by the single buffer read port). Pull transaction: a
// registered buffer read, then the output register, result on the cycle after that.
// Reset (synchronous, active high): buffer empty, no frame pending, sink
// enabled, frame limit 530. Buffer contents are not cleared.
// ----------------------------------------------------------------------------
// datagram_framer_crc8
// Buffers payload bytes, builds a 17-byte header with CRC-8 and streams the
// frame out one byte per pull.
// ----------------------------------------------------------------------------
module datagram_framer_crc8 (
   input  logic                               clock,
   input  logic                               reset,
   dfc_req_if.sink                            req_chan,
   dfc_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [dfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dfc_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import dfc_pkg::*;

   cmd_type    cmd;
   status_type status;

   dfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   dfc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_data_byte      (req_chan.data_byte),
      .req_end_of_payload (req_chan.end_of_payload),
      .req_time_us        (req_chan.time_us),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_frame_byte     (rsp_chan.frame_byte),
      .rsp_frame_valid    (rsp_chan.frame_valid),
      .rsp_frame_end      (rsp_chan.frame_end),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

endmodule
